// ----- hdl/binding_score_layout_hysteresis_core_assert.svh -----
// Assertion macros for the binding score layout hysteresis core.
`ifndef BINDING_SCORE_LAYOUT_HYSTERESIS_CORE_ASSERT_SVH
`define BINDING_SCORE_LAYOUT_HYSTERESIS_CORE_ASSERT_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define BSLH_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("bslh assertion failed");

// next-cycle implication, sampled on i_clk, off during reset
`define BSLH_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("bslh assertion failed");

`endif

// ----- hdl/bslh_pkg.sv -----
// Types, constants and register codes shared by the binding score core.
`timescale 1ns / 1ps

package bslh_pkg;

    localparam int NUM_SCALES   = 4;
    localparam int MAX_JOINTS   = 64;
    localparam int SCALE_FIELDS = 4;
    localparam int SCALE_LIM    = (NUM_SCALES < SCALE_FIELDS) ? NUM_SCALES : SCALE_FIELDS;
    localparam int JC_LIM       = (MAX_JOINTS > 127) ? 127 : MAX_JOINTS;

    localparam int SCORE_W = 17;
    localparam int DIV_W   = 32;
    localparam int QUOT_W  = 16;
    localparam int STEP_W  = $clog2(QUOT_W);

    localparam logic [SCORE_W-1:0] ONE_Q16 = 17'd65536;

    localparam logic        RST_AUTO_ENABLE       = 1'b1;
    localparam logic [16:0] RST_THRESHOLD_HIGH    = 17'd52429;
    localparam logic [16:0] RST_THRESHOLD_LOW     = 17'd19661;
    localparam logic [7:0]  RST_COOLDOWN_TICKS    = 8'd5;
    localparam logic [6:0]  RST_JOINT_COUNT       = 7'd7;
    localparam logic        RST_COLLISION_ENABLE  = 1'b0;
    localparam logic [31:0] RST_ACTIVATION_MARGIN = 32'd3277;

    typedef enum logic [2:0] {
        CFG_AUTO_ENABLE       = 3'd0,
        CFG_THRESHOLD_HIGH    = 3'd1,
        CFG_THRESHOLD_LOW     = 3'd2,
        CFG_COOLDOWN_TICKS    = 3'd3,
        CFG_JOINT_COUNT       = 3'd4,
        CFG_COLLISION_ENABLE  = 3'd5,
        CFG_ACTIVATION_MARGIN = 3'd6
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_JSTART,
        ST_JWAIT,
        ST_CWAIT,
        ST_UPDATE
    } t_state;

    typedef struct packed {
        logic               feedback_valid;
        logic signed [23:0] scale_0;
        logic signed [23:0] scale_1;
        logic signed [23:0] scale_2;
        logic signed [23:0] scale_3;
        logic [2:0]         scale_count;
        logic [3:0]         scale_finite_mask;
        logic [6:0]         saturated_count;
        logic signed [31:0] clearance;
        logic               clearance_finite;
    } t_in_word;

    typedef struct packed {
        logic               layout;
        logic [SCORE_W-1:0] binding_score;
        logic [7:0]         below_low_run;
        logic               feedback_seen;
    } t_out_word;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] x;
        logic [DIV_W-1:0] d;
    } t_div_req;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [QUOT_W-1:0] q;
    } t_div_stat;

endpackage

// ----- hdl/bslh_div.sv -----
// Bit-serial restoring divider: q = floor(x * 2^16 / d) for x < d.
`timescale 1ns / 1ps

module bslh_div (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  bslh_pkg::t_div_req   i_req,
    output bslh_pkg::t_div_stat  o_stat
);

    logic                          r_busy;
    logic                          r_done;
    logic [bslh_pkg::STEP_W-1:0]   r_cnt;
    logic [bslh_pkg::DIV_W-1:0]    r_rem;
    logic [bslh_pkg::DIV_W-1:0]    r_d;
    logic [bslh_pkg::QUOT_W-1:0]   r_q;

    logic [bslh_pkg::DIV_W:0]      w_sh;
    logic [bslh_pkg::DIV_W:0]      w_diff;
    logic                          w_ge;

    assign w_sh   = {r_rem, 1'b0};
    assign w_ge   = (w_sh >= {1'b0, r_d});
    assign w_diff = w_sh - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '1;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start && !r_busy) begin
            r_rem <= i_req.x;
            r_d   <= i_req.d;
            r_q   <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[bslh_pkg::DIV_W-1:0] : w_sh[bslh_pkg::DIV_W-1:0];
            r_q   <= {r_q[bslh_pkg::QUOT_W-2:0], w_ge};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_stat.q    = r_q;

endmodule

// ----- hdl/binding_score_layout_hysteresis_core.sv -----
// Binding score from solver feedback with merged/split layout hysteresis.
// An input word is accepted only while idle; the next word is held off until the last one reaches the output register.
// The shared 16-step serial divider runs twice per word.
// Result is held in an output register; the next word may enter while it waits.
// Reset: synchronous active-low; merged layout, zero score, registers at defaults.
`timescale 1ns / 1ps
`include "binding_score_layout_hysteresis_core_assert.svh"

module binding_score_layout_hysteresis_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  bslh_pkg::t_in_word    i_in_word,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output bslh_pkg::t_out_word   o_out_word,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [2:0]            i_cfg_index,
    input  logic [31:0]           i_cfg_data
);

    localparam int SW = bslh_pkg::SCORE_W;

    // configuration
    logic        r_auto_enable;
    logic [16:0] r_threshold_high;
    logic [16:0] r_threshold_low;
    logic [7:0]  r_cooldown_ticks;
    logic [6:0]  r_joint_count;
    logic        r_collision_enable;
    logic [31:0] r_activation_margin;

    // architectural state
    logic          r_layout;
    logic [7:0]    r_run;
    logic          r_seen;
    logic [SW-1:0] r_score;

    bslh_pkg::t_state    r_state;
    bslh_pkg::t_state    n_state;
    bslh_pkg::t_in_word  r_in;
    bslh_pkg::t_out_word r_out;
    logic                r_out_valid;
    logic [bslh_pkg::QUOT_W-1:0] r_jq;

    // scale minimum shift line
    logic signed [23:0] r_scl [4];
    logic [3:0]         r_smask;
    logic [2:0]         r_scnt;
    logic signed [24:0] r_min;

    logic in_accept;
    logic out_free;
    logic ctl_stall;
    logic ctl_start;
    logic ctl_coll;
    logic ctl_update;

    bslh_pkg::t_div_req  div_req;
    bslh_pkg::t_div_stat div_stat;

    logic [6:0]    jc_eff;
    logic [31:0]   m_eff;
    logic          c_le0;
    logic          c_ge_m;
    logic [2:0]    cnt_load;
    logic [SW-1:0] s_term;
    logic [SW-1:0] j_term;
    logic [SW-1:0] c_term;
    logic [SW-1:0] s_max;
    logic [SW-1:0] n_score;
    logic          n_seen;
    logic          n_layout;
    logic [7:0]    n_run;
    logic [7:0]    run_inc;
    logic [7:0]    cd_eff;

    assign o_cfg_ready = 1'b1;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = ctl_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_auto_enable       <= bslh_pkg::RST_AUTO_ENABLE;
            r_threshold_high    <= bslh_pkg::RST_THRESHOLD_HIGH;
            r_threshold_low     <= bslh_pkg::RST_THRESHOLD_LOW;
            r_cooldown_ticks    <= bslh_pkg::RST_COOLDOWN_TICKS;
            r_joint_count       <= bslh_pkg::RST_JOINT_COUNT;
            r_collision_enable  <= bslh_pkg::RST_COLLISION_ENABLE;
            r_activation_margin <= bslh_pkg::RST_ACTIVATION_MARGIN;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (bslh_pkg::t_cfg_idx'(i_cfg_index))
                bslh_pkg::CFG_AUTO_ENABLE:       r_auto_enable       <= i_cfg_data[0];
                bslh_pkg::CFG_THRESHOLD_HIGH:    r_threshold_high    <= i_cfg_data[16:0];
                bslh_pkg::CFG_THRESHOLD_LOW:     r_threshold_low     <= i_cfg_data[16:0];
                bslh_pkg::CFG_COOLDOWN_TICKS:    r_cooldown_ticks    <= i_cfg_data[7:0];
                bslh_pkg::CFG_JOINT_COUNT:       r_joint_count       <= i_cfg_data[6:0];
                bslh_pkg::CFG_COLLISION_ENABLE:  r_collision_enable  <= i_cfg_data[0];
                bslh_pkg::CFG_ACTIVATION_MARGIN: r_activation_margin <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bslh_pkg::ST_IDLE:   if (in_accept) n_state = bslh_pkg::ST_JSTART;
            bslh_pkg::ST_JSTART: n_state = bslh_pkg::ST_JWAIT;
            bslh_pkg::ST_JWAIT:  if (div_stat.done) n_state = bslh_pkg::ST_CWAIT;
            bslh_pkg::ST_CWAIT:  if (div_stat.done) n_state = bslh_pkg::ST_UPDATE;
            bslh_pkg::ST_UPDATE: if (out_free) n_state = bslh_pkg::ST_IDLE;
            default:             n_state = bslh_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        ctl_stall  = 1'b1;
        ctl_start  = 1'b0;
        ctl_coll   = 1'b0;
        ctl_update = 1'b0;
        unique case (r_state)
            bslh_pkg::ST_IDLE:   ctl_stall = 1'b0;
            bslh_pkg::ST_JSTART: ctl_start = 1'b1;
            bslh_pkg::ST_JWAIT: begin
                ctl_start = div_stat.done;
                ctl_coll  = 1'b1;
            end
            bslh_pkg::ST_CWAIT:  ctl_coll = 1'b1;
            bslh_pkg::ST_UPDATE: ctl_update = out_free;
            default:             ctl_stall = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bslh_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // divider operands
    assign jc_eff = (r_joint_count > 7'(bslh_pkg::JC_LIM)) ? 7'(bslh_pkg::JC_LIM)
                                                            : r_joint_count;
    assign m_eff  = (r_activation_margin == '0) ? 32'd1 : r_activation_margin;
    assign c_le0  = r_in.clearance[31] || (r_in.clearance == '0);
    assign c_ge_m = (r_in.clearance[31:0] >= m_eff);

    assign div_req.start = ctl_start;
    assign div_req.x     = ctl_coll ? (m_eff - r_in.clearance[31:0])
                                    : {25'd0, r_in.saturated_count};
    assign div_req.d     = ctl_coll ? m_eff : {25'd0, jc_eff};

    bslh_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_stat  (div_stat)
    );

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= i_in_word;
        end
        if (r_state == bslh_pkg::ST_JWAIT && div_stat.done) begin
            r_jq <= div_stat.q;
        end
    end

    // scale minimum, one scale per cycle
    assign cnt_load = (i_in_word.scale_count > 3'(bslh_pkg::SCALE_LIM))
                    ? 3'(bslh_pkg::SCALE_LIM) : i_in_word.scale_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scnt <= '0;
        end else if (in_accept) begin
            r_scnt <= cnt_load;
        end else if (r_scnt != '0) begin
            r_scnt <= r_scnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_scl[0] <= i_in_word.scale_0;
            r_scl[1] <= i_in_word.scale_1;
            r_scl[2] <= i_in_word.scale_2;
            r_scl[3] <= i_in_word.scale_3;
            r_smask  <= i_in_word.scale_finite_mask;
            r_min    <= 25'sd65536;
        end else if (r_scnt != '0) begin
            if (r_smask[0] && ($signed({r_scl[0][23], r_scl[0]}) < r_min)) begin
                r_min <= {r_scl[0][23], r_scl[0]};
            end
            r_scl[0] <= r_scl[1];
            r_scl[1] <= r_scl[2];
            r_scl[2] <= r_scl[3];
            r_smask  <= {1'b0, r_smask[3:1]};
        end
    end

    // terms and hysteresis
    always_comb begin
        if (r_min >= 25'sd65536) begin
            s_term = '0;
        end else if (r_min <= 25'sd0) begin
            s_term = bslh_pkg::ONE_Q16;
        end else begin
            s_term = bslh_pkg::ONE_Q16 - r_min[SW-1:0];
        end

        if (jc_eff == '0) begin
            j_term = '0;
        end else if (r_in.saturated_count >= jc_eff) begin
            j_term = bslh_pkg::ONE_Q16;
        end else begin
            j_term = {1'b0, r_jq};
        end

        if (!r_collision_enable || !r_in.clearance_finite) begin
            c_term = '0;
        end else if (c_le0) begin
            c_term = bslh_pkg::ONE_Q16;
        end else if (c_ge_m) begin
            c_term = '0;
        end else begin
            c_term = {1'b0, div_stat.q};
        end

        s_max = (j_term > s_term) ? j_term : s_term;
        s_max = (c_term > s_max) ? c_term : s_max;

        n_score  = r_score;
        n_seen   = r_seen;
        n_layout = r_layout;
        n_run    = r_run;
        cd_eff   = (r_cooldown_ticks == '0) ? 8'd1 : r_cooldown_ticks;
        run_inc  = (r_run == 8'hFF) ? r_run : r_run + 8'd1;
        if (r_auto_enable) begin
            if (r_in.feedback_valid) begin
                n_score = s_max;
                n_seen  = 1'b1;
            end
            if (n_seen) begin
                if (!r_layout) begin
                    if (n_score > r_threshold_high) begin
                        n_layout = 1'b1;
                        n_run    = '0;
                    end
                end else if (n_score < r_threshold_low) begin
                    if (run_inc >= cd_eff) begin
                        n_layout = 1'b0;
                        n_run    = '0;
                    end else begin
                        n_run = run_inc;
                    end
                end else begin
                    n_run = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_layout    <= 1'b0;
            r_run       <= '0;
            r_seen      <= 1'b0;
            r_score     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (ctl_update) begin
                r_layout    <= n_layout;
                r_run       <= n_run;
                r_seen      <= n_seen;
                r_score     <= n_score;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl_update) begin
            r_out.layout        <= n_layout;
            r_out.binding_score <= n_score;
            r_out.below_low_run <= n_run;
            r_out.feedback_seen <= n_seen;
        end
    end

    `BSLH_ASSERT_NOW(a_run_only_split, r_run != '0, r_layout)
    `BSLH_ASSERT_NOW(a_unseen_clear, !r_seen, !r_layout && (r_score == '0))
    `BSLH_ASSERT_NOW(a_score_range, 1'b1, r_score <= bslh_pkg::ONE_Q16)
    `BSLH_ASSERT_NOW(a_div_in_wait, div_stat.busy,
        (r_state == bslh_pkg::ST_JWAIT) || (r_state == bslh_pkg::ST_CWAIT))
    `BSLH_ASSERT_NEXT(a_accept_starts, in_accept, r_state == bslh_pkg::ST_JSTART)

endmodule
